FILE: hw/rtl/vector3_normalize_top_defines.svh
// Assertion macros used by the top-level RTL file of the vector normalizer.
`ifndef VECTOR3_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_NORMALIZE_TOP_DEFINES_SVH

// An implication that is checked at every rising clock edge outside reset.
`define V3N_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A next-cycle implication that is checked outside reset.
`define V3N_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/v3n_pkg.sv
`default_nettype none
package v3n_pkg;

   // Widths of the component and result fields.
   localparam int unsigned COMP_W = 16;
   localparam int unsigned MAG_W  = 16;
   localparam int unsigned SUM_W  = 33;
   localparam int unsigned Q_W    = 15;
   localparam int unsigned RHS_W  = 62;
   localparam int unsigned LIN_W  = 48;
   localparam int unsigned PROD_W = 63;

   // Number of search cells: one result bit per cell, most significant first.
   localparam int unsigned NUM_BITS = 15;

   // Full scale 1.0 in the 2.14 result format.
   localparam logic [Q_W-1:0] UNIT_ONE = 15'd16384;

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic                     zero_length;
      logic                     last_out;
   } rsp_type;

   // Search state of one component: the partial result q, the running
   // product (2q-1)^2 * s and the running term 2q * s.
   typedef struct packed {
      logic [Q_W-1:0]    q;
      logic [PROD_W-1:0] acc;
      logic [LIN_W-1:0]  lin;
   } search_type;

   // Working state that one cell hands to the next.
   typedef struct packed {
      logic              valid;
      logic [2:0]        neg;
      logic [SUM_W-1:0]  sum_sq;
      logic [RHS_W-1:0]  rhs_x;
      logic [RHS_W-1:0]  rhs_y;
      logic [RHS_W-1:0]  rhs_z;
      search_type        srch_x;
      search_type        srch_y;
      search_type        srch_z;
      logic              last;
   } lane_type;

endpackage
`default_nettype wire

FILE: hw/rtl/v3n_stream_if.sv
`default_nettype none
interface v3n_stream_if #(
   parameter int unsigned WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/vector3_normalize_top.sv
// Pipeline: an input transfer reaches its result through one prep stage,
// fifteen search cells (one result bit each) and the output register.
// Throughput: one vector per cycle; the whole chain advances whenever the
// output register is empty or being drained.
// Reset: synchronous, active high; clears all stage valid bits.
`default_nettype none
`include "vector3_normalize_top_defines.svh"
module vector3_normalize_top (
   input  wire logic    clock,
   input  wire logic    reset,
   v3n_stream_if.sink   req,
   v3n_stream_if.source rsp
);
   import v3n_pkg::*;

   lane_type         chain [NUM_BITS+1];
   logic             enable;
   logic             rsp_valid_ff;
   rsp_type          rsp_in, rsp_ff;
   logic             zero;
   logic [Q_W-1:0]   fx, fy, fz;

   // The chain moves when the output slot is free or its transfer completes.
   assign enable    = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;

   v3n_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req.valid),
      .in_req   (req_type'(req.payload)),
      .out_lane (chain[0])
   );

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
      v3n_cell #(.BIT_POS(NUM_BITS - 1 - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_lane  (chain[i]),
         .out_lane (chain[i+1])
      );
   end

   // Apply the signs and flag the all-zero vector.
   always_comb begin
      zero = (chain[NUM_BITS].sum_sq == '0);
      fx   = zero ? '0 : chain[NUM_BITS].srch_x.q;
      fy   = zero ? '0 : chain[NUM_BITS].srch_y.q;
      fz   = zero ? '0 : chain[NUM_BITS].srch_z.q;
      rsp_in.unit_x = chain[NUM_BITS].neg[0] ? -$signed({1'b0, fx}) : $signed({1'b0, fx});
      rsp_in.unit_y = chain[NUM_BITS].neg[1] ? -$signed({1'b0, fy}) : $signed({1'b0, fy});
      rsp_in.unit_z = chain[NUM_BITS].neg[2] ? -$signed({1'b0, fz}) : $signed({1'b0, fz});
      rsp_in.zero_length = zero;
      rsp_in.last_out    = chain[NUM_BITS].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= chain[NUM_BITS].valid;
      end
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `V3N_ASSERT_NEXT(a_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff && $stable(rsp_ff), "stalled result changed")
   `V3N_ASSERT_IMPLY(a_zero, clock, reset, rsp_valid_ff && rsp_ff.zero_length, rsp_ff.unit_x == 0 && rsp_ff.unit_y == 0 && rsp_ff.unit_z == 0, "zero vector gave nonzero result")
   `V3N_ASSERT_IMPLY(a_range, clock, reset, rsp_valid_ff, rsp_ff.unit_x <= 16384 && rsp_ff.unit_x >= -16384, "result out of range")
endmodule
`default_nettype wire

FILE: hw/rtl/v3n_prep.sv
`default_nettype none
module v3n_prep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire v3n_pkg::req_type  in_req,
   output v3n_pkg::lane_type      out_lane
);
   import v3n_pkg::*;

   logic [MAG_W-1:0]    ax, ay, az;
   logic [2*MAG_W-1:0]  sx, sy, sz;
   lane_type            lane_in, lane_ff;

   // Magnitudes of the components; the most negative value maps to 32768.
   always_comb begin
      ax = in_req.comp_x[COMP_W-1] ? MAG_W'(-in_req.comp_x) : MAG_W'(in_req.comp_x);
      ay = in_req.comp_y[COMP_W-1] ? MAG_W'(-in_req.comp_y) : MAG_W'(in_req.comp_y);
      az = in_req.comp_z[COMP_W-1] ? MAG_W'(-in_req.comp_z) : MAG_W'(in_req.comp_z);
      sx = ax * ax;
      sy = ay * ay;
      sz = az * az;
   end

   // Squared length and the per-component targets (mag * 2^15)^2 = mag^2 * 2^30.
   // The search starts at q = 0, where (2q-1)^2 * s is s itself.
   always_comb begin
      lane_in        = '0;
      lane_in.valid  = in_valid;
      lane_in.neg    = {in_req.comp_z[COMP_W-1], in_req.comp_y[COMP_W-1],
                        in_req.comp_x[COMP_W-1]};
      lane_in.sum_sq = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
      lane_in.rhs_x  = {sx, 30'd0};
      lane_in.rhs_y  = {sy, 30'd0};
      lane_in.rhs_z  = {sz, 30'd0};
      lane_in.srch_x.acc = PROD_W'(lane_in.sum_sq);
      lane_in.srch_y.acc = PROD_W'(lane_in.sum_sq);
      lane_in.srch_z.acc = PROD_W'(lane_in.sum_sq);
      lane_in.last   = in_req.last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (enable) begin
         lane_ff.valid <= lane_in.valid;
      end
      if (enable) begin
         lane_ff.neg    <= lane_in.neg;
         lane_ff.sum_sq <= lane_in.sum_sq;
         lane_ff.rhs_x  <= lane_in.rhs_x;
         lane_ff.rhs_y  <= lane_in.rhs_y;
         lane_ff.rhs_z  <= lane_in.rhs_z;
         lane_ff.srch_x <= lane_in.srch_x;
         lane_ff.srch_y <= lane_in.srch_y;
         lane_ff.srch_z <= lane_in.srch_z;
         lane_ff.last   <= lane_in.last;
      end
   end

   assign out_lane = lane_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/v3n_cell.sv
`default_nettype none
module v3n_cell #(
   parameter int unsigned BIT_POS = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire v3n_pkg::lane_type in_lane,
   output v3n_pkg::lane_type      out_lane
);
   import v3n_pkg::*;

   lane_type lane_in, lane_ff;

   // Trial value k = q | bit; keep it when (2k-1)^2 * s <= rhs and k <= 1.0.
   // Since q holds only bits above this one, 2k-1 = (2q-1) + 2^(b+1), so the
   // trial product is the running product plus shifted copies of 2q * s and s.
   function automatic search_type try_bit(
      input search_type       cur,
      input logic [SUM_W-1:0] s,
      input logic [RHS_W-1:0] rhs
   );
      search_type        nxt;
      logic [Q_W-1:0]    k;
      logic [PROD_W-1:0] s_w;
      logic [PROD_W-1:0] trial;
      begin
         k     = cur.q | (Q_W'(1) << BIT_POS);
         s_w   = PROD_W'(s);
         trial = cur.acc + (PROD_W'(cur.lin) << (BIT_POS + 2))
               - (s_w << (BIT_POS + 2)) + (s_w << (2 * BIT_POS + 2));
         nxt   = cur;
         if (k <= UNIT_ONE && trial <= PROD_W'(rhs)) begin
            nxt.q   = k;
            nxt.acc = trial;
            nxt.lin = cur.lin + (LIN_W'(s) << (BIT_POS + 1));
         end
         try_bit = nxt;
      end
   endfunction

   always_comb begin
      lane_in        = in_lane;
      lane_in.srch_x = try_bit(in_lane.srch_x, in_lane.sum_sq, in_lane.rhs_x);
      lane_in.srch_y = try_bit(in_lane.srch_y, in_lane.sum_sq, in_lane.rhs_y);
      lane_in.srch_z = try_bit(in_lane.srch_z, in_lane.sum_sq, in_lane.rhs_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (enable) begin
         lane_ff.valid <= lane_in.valid;
      end
      if (enable) begin
         lane_ff.neg    <= lane_in.neg;
         lane_ff.sum_sq <= lane_in.sum_sq;
         lane_ff.rhs_x  <= lane_in.rhs_x;
         lane_ff.rhs_y  <= lane_in.rhs_y;
         lane_ff.rhs_z  <= lane_in.rhs_z;
         lane_ff.srch_x <= lane_in.srch_x;
         lane_ff.srch_y <= lane_in.srch_y;
         lane_ff.srch_z <= lane_in.srch_z;
         lane_ff.last   <= lane_in.last;
      end
   end

   assign out_lane = lane_ff;
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
   import v3n_pkg::*;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   v3n_stream_if #(.WIDTH(REQ_W)) req_ch ();
   v3n_stream_if #(.WIDTH(RSP_W)) rsp_ch ();

   vector3_normalize_top u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   rsp_type unit_queue[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_off = 1'b0;

   // Directed table: vector and, where obvious, the expected result.
   typedef struct {
      req_type vec;
      bit      has_expected;
      rsp_type expected;
   } vector_row_type;

   vector_row_type directed_rows[$];

   // Rounded magnitude of mag * 2^14 / sqrt(sum), found by binary search.
   function automatic logic [14:0] scaled_magnitude(logic [15:0] mag, logic [33:0] sum);
      logic [63:0]  rhs;
      logic [15:0]  lo;
      logic [15:0]  hi;
      logic [15:0]  mid;
      logic [31:0]  odd;
      logic [127:0] lhs;
      rhs = ({48'd0, mag} << 15) * ({48'd0, mag} << 15);
      lo = 16'd0;
      hi = 16'd16384;
      while (lo < hi) begin
         mid = (lo + hi + 16'd1) / 16'd2;
         odd = 2 * {16'd0, mid} - 32'd1;
         lhs = {96'd0, odd} * {96'd0, odd} * {94'd0, sum};
         if (lhs <= {64'd0, rhs}) begin
            lo = mid;
         end else begin
            hi = mid - 16'd1;
         end
      end
      return lo[14:0];
   endfunction

   function automatic logic [15:0] magnitude_of(logic signed [15:0] c);
      return c[15] ? 16'(-$signed({c[15], c})) : 16'(c);
   endfunction

   function automatic logic signed [15:0] apply_sign(logic signed [15:0] c, logic [14:0] q);
      return c[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   function automatic rsp_type normalize_vector(req_type v);
      rsp_type     r;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] az;
      logic [33:0] sum;
      ax = magnitude_of(v.comp_x);
      ay = magnitude_of(v.comp_y);
      az = magnitude_of(v.comp_z);
      sum = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay) + 34'(az) * 34'(az);
      if (sum == 0) begin
         r.unit_x = '0;
         r.unit_y = '0;
         r.unit_z = '0;
         r.zero_length = 1'b1;
      end else begin
         r.unit_x = apply_sign(v.comp_x, scaled_magnitude(ax, sum));
         r.unit_y = apply_sign(v.comp_y, scaled_magnitude(ay, sum));
         r.unit_z = apply_sign(v.comp_z, scaled_magnitude(az, sum));
         r.zero_length = 1'b0;
      end
      r.last_out = v.last_in;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic add_row(int x, int y, int z, bit last, bit known = 0,
                          int ux = 0, int uy = 0, int uz = 0, bit zl = 0);
      vector_row_type row;
      row.vec = '{comp_x: 16'(x), comp_y: 16'(y), comp_z: 16'(z), last_in: last};
      row.has_expected = known;
      row.expected = '{unit_x: 16'(ux), unit_y: 16'(uy), unit_z: 16'(uz),
                       zero_length: zl, last_out: last};
      directed_rows.push_back(row);
   endtask

   // Send one vector; the queued expectation is taken from the table or the predictor.
   task automatic send_vector(req_type v, bit known, rsp_type want);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      unit_queue.push_back(known ? want : normalize_vector(v));
   endtask

   function automatic logic signed [15:0] random_component();
      case ($urandom_range(5, 0))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($signed($urandom_range(8, 0)) - 4);
         3: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver readiness and the long hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (unit_queue.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = unit_queue.pop_front();
            if (got.unit_x !== want.unit_x)
               report_mismatch("unit_x", got.unit_x, want.unit_x);
            if (got.unit_y !== want.unit_y)
               report_mismatch("unit_y", got.unit_y, want.unit_y);
            if (got.unit_z !== want.unit_z)
               report_mismatch("unit_z", got.unit_z, want.unit_z);
            if (got.zero_length !== want.zero_length)
               report_mismatch("zero_length", got.zero_length, want.zero_length);
            if (got.last_out !== want.last_out)
               report_mismatch("last_out", got.last_out, want.last_out);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog timeout");
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Main stimulus.
   initial begin
      req_type v;
      rsp_type none;
      none = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero vector, axes at full scale, extremes and a rounding case.
      add_row(0, 0, 0, 0, 1, 0, 0, 0, 1);
      add_row(0, 0, 0, 1, 1, 0, 0, 0, 1);
      add_row(32767, 0, 0, 0, 1, 16384, 0, 0, 0);
      add_row(-32768, 0, 0, 1, 1, -16384, 0, 0, 0);
      add_row(0, 1, 0, 0, 1, 0, 16384, 0, 0);
      add_row(0, 0, -1, 0, 1, 0, 0, -16384, 0);
      add_row(0, -32768, 0, 1, 1, 0, -16384, 0, 0);
      add_row(0, 0, 32767, 0, 1, 0, 0, 16384, 0);
      add_row(3, 4, 0, 0, 1, 9830, 13107, 0, 0);
      add_row(-32768, -32768, -32768, 1);
      add_row(32767, 32767, 32767, 0);
      add_row(32767, -32768, 32767, 1);
      add_row(1, 1, 1, 0);
      add_row(-1, 1, -1, 0);
      add_row(1, 32767, 0, 1);
      add_row(-32768, 1, -1, 0);
      add_row(2, 1, 2, 0);
      add_row(12345, -23456, 1, 1);
      foreach (directed_rows[i])
         send_vector(directed_rows[i].vec, directed_rows[i].has_expected,
                     directed_rows[i].expected);

      // Random rows across idling phases.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 200; n++) begin
            v.comp_x = random_component();
            v.comp_y = random_component();
            v.comp_z = random_component();
            v.last_in = $urandom_range(1, 0);
            send_vector(v, 0, none);
         end
      end
      req_ch.valid <= 1'b0;

      while (unit_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
